// ===== sv/crc16_frame_receiver_assert.svh =====
// Assertion macros used by the frame receiver parser.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef CRC16_FRAME_RECEIVER_ASSERT_SVH
`define CRC16_FRAME_RECEIVER_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is high.
`define FRX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds across reset.
`define FRX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRX_ASSERT(lbl, clk, rst, prop, msg)
`define FRX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/frx_pkg.sv =====
// Shared types, codes and the CRC16-CCITT byte update for the frame receiver.
// Depends on nothing; every other file of the block uses it but frx_in_reg and the assertion header.
`timescale 1ns / 1ps

package frx_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_START_BYTE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_END_BYTE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PAYLOAD = 2'd2;

   localparam logic [7:0]  START_BYTE_RESET  = 8'h02;
   localparam logic [7:0]  END_BYTE_RESET    = 8'h03;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd512;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
   localparam logic [1:0] STATUS_NO_END   = 2'd2;
   localparam logic [1:0] STATUS_OVER_MAX = 2'd3;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] max_payload_len;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  command;
      logic [7:0]  data;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
      logic [1:0]  status;
   } result_type;

   // One byte of CRC16-CCITT, most significant bit first, no final xor.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/crc16_frame_receiver.sv =====
// Top level of the CRC16 frame receiver: request and response channels, configuration port.
// Depends on frx_pkg, frx_csr, frx_in_reg, frx_parser and frx_out_reg.
`timescale 1ns / 1ps

// Usage
// Each request carries one byte received from the serial link on req_rx_byte. The
// receiver hunts for the start byte, then reads a little-endian length, a command
// byte, the payload, a little-endian CRC16-CCITT and the end byte. Every payload byte
// within the configured limit comes out as a response of kind zero; when the frame
// closes, one response of kind one reports the command, the declared length, the
// payload count and a status. Other bytes produce no response.
// A request accepted into the input register is parsed there, and its response, if any,
// is loaded into the response register and shows on rsp_valid; the parser steps on the
// held byte only while the response register is free to take that response.
// Throughput is one request per cycle while the response side does not stall, set by the
// combinational byte update of the CRC and the phase sequencer.
// When the response side stalls, the held response waits in the response register
// and one further request waits in the input register; req_ready then drops until
// the consumer takes the response. Reset clears both registers, returns the parser
// to hunting for a start byte and loads the configuration defaults: start byte 2,
// end byte 3 and a payload limit of 512. Configuration is written through csr_we,
// csr_index and csr_wdata and should only change while the receiver is idle.
module crc16_frame_receiver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_kind,
   output logic [7:0]                       rsp_command,
   output logic [7:0]                       rsp_data,
   output logic [15:0]                      rsp_byte_index,
   output logic [15:0]                      rsp_frame_length,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_we,
   input  logic [frx_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [frx_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   frx_pkg::cfg_type    cfg;
   frx_pkg::result_type res;
   frx_pkg::result_type rsp;
   logic                res_valid;
   logic                out_free;
   logic                byte_valid;
   logic [7:0]          byte_value;
   logic                advance;

   // The parser steps on a held byte only when the response register can take
   // whatever that byte produces.
   assign advance = byte_valid && out_free;

   frx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   frx_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (advance),
      .byte_valid  (byte_valid),
      .byte_value  (byte_value)
   );

   frx_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .rx_byte   (byte_value),
      .res_valid (res_valid),
      .res       (res)
   );

   frx_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind         = rsp.kind;
   assign rsp_command      = rsp.command;
   assign rsp_data         = rsp.data;
   assign rsp_byte_index   = rsp.byte_index;
   assign rsp_frame_length = rsp.frame_length;
   assign rsp_status       = rsp.status;

endmodule

// ===== sv/frx_csr.sv =====
// Configuration registers of the frame receiver: start byte, end byte, payload limit.
// Depends on frx_pkg.
`timescale 1ns / 1ps

module frx_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [frx_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [frx_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output frx_pkg::cfg_type                 cfg
);

   frx_pkg::cfg_type cfg_ff;
   frx_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            frx_pkg::REG_START_BYTE:  cfg_in.start_byte      = csr_wdata[7:0];
            frx_pkg::REG_END_BYTE:    cfg_in.end_byte        = csr_wdata[7:0];
            frx_pkg::REG_MAX_PAYLOAD: cfg_in.max_payload_len = csr_wdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte      <= frx_pkg::START_BYTE_RESET;
         cfg_ff.end_byte        <= frx_pkg::END_BYTE_RESET;
         cfg_ff.max_payload_len <= frx_pkg::MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/frx_in_reg.sv =====
// Input register of the frame receiver: holds one received byte until the parser takes it.
// Depends on frx_pkg only through the shared file set; no package items are used here.
`timescale 1ns / 1ps

module frx_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_value
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // The slot can be refilled in the same cycle that the parser drains it.
   assign req_ready = !valid_ff || take;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_value = byte_ff;

endmodule

// ===== sv/frx_parser.sv =====
// Frame parser: phase sequencer, length and CRC tracking, and result formation.
// Depends on frx_pkg and crc16_frame_receiver_assert.svh.
`timescale 1ns / 1ps
`include "crc16_frame_receiver_assert.svh"

module frx_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  frx_pkg::cfg_type     cfg,
   input  logic                 advance,
   input  logic [7:0]           rx_byte,
   output logic                 res_valid,
   output frx_pkg::result_type  res
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_LEN_LO  = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_CMD     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_CRC_LO  = 3'd5;
   localparam logic [2:0] PH_CRC_HI  = 3'd6;
   localparam logic [2:0] PH_END     = 3'd7;

   logic [2:0]  phase_ff,           phase_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [15:0] bytes_received_ff,  bytes_received_in;
   logic [7:0]  frame_command_ff,   frame_command_in;
   logic [15:0] running_crc_ff,     running_crc_in;
   logic [15:0] received_crc_ff,    received_crc_in;

   logic [15:0] crc_next;
   logic [15:0] count_next;
   logic        emit;

   assign crc_next   = frx_pkg::crc_feed(running_crc_ff, rx_byte);
   assign count_next = bytes_received_ff + 16'd1;

   always_comb begin
      phase_in           = phase_ff;
      declared_length_in = declared_length_ff;
      bytes_received_in  = bytes_received_ff;
      frame_command_in   = frame_command_ff;
      running_crc_in     = running_crc_ff;
      received_crc_in    = received_crc_ff;
      emit               = 1'b0;
      res.kind           = frx_pkg::KIND_DATA;
      res.command        = frame_command_ff;
      res.data           = rx_byte;
      res.byte_index     = bytes_received_ff;
      res.frame_length   = declared_length_ff;
      res.status         = frx_pkg::STATUS_OK;

      unique case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == cfg.start_byte) begin
               phase_in          = PH_LEN_LO;
               bytes_received_in = 16'd0;
               running_crc_in    = frx_pkg::CRC_INIT;
            end
         end
         PH_LEN_LO: begin
            declared_length_in = {8'h00, rx_byte};
            phase_in           = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            declared_length_in = {rx_byte, declared_length_ff[7:0]};
            phase_in           = PH_CMD;
         end
         PH_CMD: begin
            frame_command_in = rx_byte;
            running_crc_in   = crc_next;
            phase_in         = (declared_length_ff != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
         end
         PH_PAYLOAD: begin
            running_crc_in    = crc_next;
            emit              = (bytes_received_ff < cfg.max_payload_len);
            bytes_received_in = count_next;
            if (count_next >= declared_length_ff) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            received_crc_in = {8'h00, rx_byte};
            phase_in        = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            received_crc_in = {rx_byte, received_crc_ff[7:0]};
            phase_in        = PH_END;
         end
         PH_END: begin
            emit      = 1'b1;
            res.kind  = frx_pkg::KIND_END;
            res.data  = 8'h00;
            phase_in  = PH_IDLE;
            priority if (rx_byte != cfg.end_byte) begin
               res.status = frx_pkg::STATUS_NO_END;
            end else if (declared_length_ff > cfg.max_payload_len) begin
               res.status = frx_pkg::STATUS_OVER_MAX;
            end else if (received_crc_ff != running_crc_ff) begin
               res.status = frx_pkg::STATUS_CRC_BAD;
            end else begin
               res.status = frx_pkg::STATUS_OK;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign res_valid = advance && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         declared_length_ff <= 16'd0;
         bytes_received_ff  <= 16'd0;
         frame_command_ff   <= 8'h00;
         running_crc_ff     <= frx_pkg::CRC_INIT;
         received_crc_ff    <= 16'd0;
      end else if (advance) begin
         phase_ff           <= phase_in;
         declared_length_ff <= declared_length_in;
         bytes_received_ff  <= bytes_received_in;
         frame_command_ff   <= frame_command_in;
         running_crc_ff     <= running_crc_in;
         received_crc_ff    <= received_crc_in;
      end
   end

   `FRX_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (phase_ff == PH_IDLE), "parser not idle after reset")
   `FRX_ASSERT(a_payload_bound, clock, reset, (phase_ff == PH_PAYLOAD) |-> (bytes_received_ff < declared_length_ff), "payload count reached declared length")
   `FRX_ASSERT(a_data_status, clock, reset, (res_valid && (res.kind == frx_pkg::KIND_DATA)) |-> (res.status == frx_pkg::STATUS_OK), "payload result carries a status")
   `FRX_ASSERT(a_end_to_idle, clock, reset, (res_valid && (res.kind == frx_pkg::KIND_END)) |=> (phase_ff == PH_IDLE), "frame end not followed by idle")

endmodule

// ===== sv/frx_out_reg.sv =====
// Result register of the frame receiver: holds one result until the consumer takes it.
// Depends on frx_pkg.
`timescale 1ns / 1ps

module frx_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  frx_pkg::result_type  res,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output frx_pkg::result_type  rsp
);

   logic                valid_ff;
   logic                valid_in;
   frx_pkg::result_type res_ff;

   // Free when empty or when the held result leaves at this edge.
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;

endmodule

// ===== tb/crc16_frame_receiver_test.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for crc16_frame_receiver: directed frames, then random traffic
// over several delimiter and limit settings, with random idling on both channels.
// Depends on frx_pkg and the crc16_frame_receiver RTL.

module crc16_frame_receiver_test;
   import frx_pkg::*;

   // Random requests per setting; the first random-traffic setting also carries one long frame.
   localparam int unsigned PHASE_ITEMS   = 220;
   // Cycles allowed after the last response before the settings may change. The block
   // holds a request in its input register, so a request that causes no response may still be
   // in flight when the last awaited response has arrived.
   localparam int unsigned SETTLE_CYCLES = 4;
   // Length of the deliberate response-side hold-off, long enough to back up the input.
   localparam int unsigned LONG_HOLD     = 64;
   // Far beyond the slowest correct run.
   localparam int unsigned TIMEOUT_NS    = 3_000_000;
   // The index port is two bits wide, so one index lies beyond the register list.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef enum logic [2:0] {
      RX_HUNT, RX_LEN_LO, RX_LEN_HI, RX_COMMAND, RX_PAYLOAD, RX_CRC_LO, RX_CRC_HI, RX_TAIL
   } rx_phase_type;

   // Tracks the deframer byte by byte and keeps the responses that are still awaited.
   class frame_checker;
      logic [7:0]   start_val;
      logic [7:0]   end_val;
      logic [15:0]  limit_val;
      rx_phase_type state;
      logic [15:0]  length;
      logic [15:0]  count;
      logic [7:0]   command;
      logic [15:0]  crc_acc;
      logic [15:0]  crc_rx;
      result_type   awaited[$];
      int unsigned  mismatches;
      int unsigned  payload_seen;
      int unsigned  closes_seen[4];

      function new();
         start_val    = START_BYTE_RESET;
         end_val      = END_BYTE_RESET;
         limit_val    = MAX_PAYLOAD_RESET;
         state        = RX_HUNT;
         length       = 16'd0;
         count        = 16'd0;
         command      = 8'd0;
         crc_acc      = CRC_INIT;
         crc_rx       = 16'd0;
         mismatches   = 0;
         payload_seen = 0;
         foreach (closes_seen[i]) closes_seen[i] = 0;
      endfunction

      // CRC16-CCITT, one bit at a time from the top of the byte.
      static function logic [15:0] ccitt_step(logic [15:0] crc, logic [7:0] value);
         logic [15:0] r;
         logic        feedback;
         int          i;
         r = crc;
         for (i = 7; i >= 0; i--) begin
            feedback = r[15] ^ value[i];
            r = {r[14:0], 1'b0};
            if (feedback) r = r ^ CRC_POLY;
         end
         return r;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_START_BYTE:  start_val = value[7:0];
            REG_END_BYTE:    end_val   = value[7:0];
            REG_MAX_PAYLOAD: limit_val = value;
            default: ;
         endcase
      endfunction

      function void queue_result(logic kind, logic [7:0] data, logic [15:0] index,
                                 logic [1:0] status);
         result_type r;
         r.kind         = kind;
         r.command      = command;
         r.data         = data;
         r.byte_index   = index;
         r.frame_length = length;
         r.status       = status;
         awaited.push_back(r);
      endfunction

      function void take_byte(logic [7:0] value);
         logic [1:0] status;
         case (state)
            RX_HUNT: begin
               if (value == start_val) begin
                  state   = RX_LEN_LO;
                  count   = 16'd0;
                  crc_acc = CRC_INIT;
               end
            end
            RX_LEN_LO: begin
               length = {8'h00, value};
               state  = RX_LEN_HI;
            end
            RX_LEN_HI: begin
               length[15:8] = value;
               state        = RX_COMMAND;
            end
            RX_COMMAND: begin
               command = value;
               crc_acc = ccitt_step(crc_acc, value);
               state   = (length != 16'd0) ? RX_PAYLOAD : RX_CRC_LO;
            end
            RX_PAYLOAD: begin
               crc_acc = ccitt_step(crc_acc, value);
               if (count < limit_val) queue_result(KIND_DATA, value, count, STATUS_OK);
               count = count + 16'd1;
               if (count >= length) state = RX_CRC_LO;
            end
            RX_CRC_LO: begin
               crc_rx = {8'h00, value};
               state  = RX_CRC_HI;
            end
            RX_CRC_HI: begin
               crc_rx[15:8] = value;
               state        = RX_TAIL;
            end
            default: begin
               if (value != end_val) status = STATUS_NO_END;
               else if (length > limit_val) status = STATUS_OVER_MAX;
               else if (crc_rx != crc_acc) status = STATUS_CRC_BAD;
               else status = STATUS_OK;
               queue_result(KIND_END, 8'h00, count, status);
               state = RX_HUNT;
            end
         endcase
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task match_response(result_type got);
         result_type want;
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("response with nothing awaited: kind %0d index %0d",
                                      got.kind, got.byte_index));
            return;
         end
         want = awaited.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.command !== want.command)
            report_mismatch($sformatf("command %h, want %h", got.command, want.command));
         if (got.data !== want.data)
            report_mismatch($sformatf("data %h, want %h", got.data, want.data));
         if (got.byte_index !== want.byte_index)
            report_mismatch($sformatf("byte_index %0d, want %0d",
                                      got.byte_index, want.byte_index));
         if (got.frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length %0d, want %0d",
                                      got.frame_length, want.frame_length));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (want.kind == KIND_END) closes_seen[want.status]++;
         else payload_seen++;
      endtask
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic                   rsp_kind;
   logic [7:0]             rsp_command;
   logic [7:0]             rsp_data;
   logic [15:0]            rsp_byte_index;
   logic [15:0]            rsp_frame_length;
   logic [1:0]             rsp_status;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   frame_checker board;
   int unsigned  requests_sent = 0;
   int unsigned  req_burst     = 0;
   // Raised by the stimulus to ask the response side for one long hold-off.
   bit           stall_request = 1'b0;

   always #5 clock = ~clock;

   crc16_frame_receiver i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_command      (rsp_command),
      .rsp_data         (rsp_data),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_length (rsp_frame_length),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Offers one request and returns at the edge where it is accepted. Valid is left high,
   // so that a following request with no gap keeps it high without a second assignment in
   // the same time step; whoever stops sending lowers it at that same step.
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      if (req_burst > 0) begin
         gap = 0;
         req_burst--;
      end else if ($urandom_range(0, 19) == 0) begin
         gap = 0;
         req_burst = $urandom_range(10, 40);
      end else begin
         gap = $urandom_range(0, 7);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_byte(value);
      requests_sent++;
   endtask

   // Sends a whole frame with random payload under the current start byte. The CRC can
   // be spoiled by an XOR mask, and the closing byte is chosen by the caller.
   task automatic drive_frame(input logic [7:0] command, input logic [15:0] length,
                              input logic [15:0] crc_flip, input logic [7:0] closing);
      logic [15:0] crc;
      logic [7:0]  value;
      int unsigned i;
      send_byte(board.start_val);
      send_byte(length[7:0]);
      send_byte(length[15:8]);
      send_byte(command);
      crc = frame_checker::ccitt_step(CRC_INIT, command);
      for (i = 0; i < length; i++) begin
         value = 8'($urandom);
         crc   = frame_checker::ccitt_step(crc, value);
         send_byte(value);
      end
      crc = crc ^ crc_flip;
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      send_byte(closing);
   endtask

   // Holds the input idle until every awaited response is in and the pipeline is empty.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register_port(input logic [CSR_INDEX_W-1:0] index,
                                      input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
   endtask

   // Writes all three registers on consecutive edges. The byte-wide registers get random
   // upper bits, which the block must drop; optionally the unused index is written too.
   task automatic write_settings(input logic [7:0] start_value, input logic [7:0] end_value,
                                 input logic [15:0] limit, input bit poke_spare);
      logic [7:0] junk;
      junk = 8'($urandom);
      write_register_port(REG_START_BYTE, {junk, start_value});
      write_register_port(REG_END_BYTE, {~junk, end_value});
      write_register_port(REG_MAX_PAYLOAD, limit);
      if (poke_spare) write_register_port(REG_SPARE, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   // Mostly well-formed frames with random content and short lengths, with occasional
   // noise between frames. About one frame in eight has a spoiled CRC and one in eight a
   // wrong closing byte, which is sometimes the start byte itself.
   task automatic random_traffic(input int unsigned budget, input logic [15:0] big_length);
      int unsigned first;
      int unsigned n;
      logic [15:0] length;
      logic [15:0] crc_flip;
      logic [7:0]  noise;
      logic [7:0]  closing;
      first = requests_sent;
      if (big_length != 16'd0) drive_frame(8'($urandom), big_length, 16'h0000, board.end_val);
      while (requests_sent - first < budget) begin
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               noise = 8'($urandom);
               if (noise == board.start_val) noise = ~noise;
               send_byte(noise);
            end
         end
         if ($urandom_range(0, 9) == 0) length = 16'($urandom_range(13, 40));
         else length = 16'($urandom_range(0, 12));
         crc_flip = 16'h0000;
         if ($urandom_range(0, 7) == 0) crc_flip = 16'h0001 << $urandom_range(0, 15);
         closing = board.end_val;
         if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 2) == 0) closing = board.start_val;
            else closing = board.end_val ^ (8'h01 << $urandom_range(0, 7));
            // The start byte may be configured equal to the end byte.
            if (closing == board.end_val) closing = ~closing;
         end
         drive_frame(8'($urandom), length, crc_flip, closing);
      end
   endtask

   // Response side: takes one response per handshake after a random hold-off, with
   // stretches of no hold-off, and once a long stall when the stimulus asks for it.
   initial begin : response_side
      int unsigned gap;
      int unsigned burst;
      result_type  got;
      burst = 0;
      while (reset) @(posedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            gap = LONG_HOLD;
         end else if (burst > 0) begin
            gap = 0;
            burst--;
         end else if ($urandom_range(0, 19) == 0) begin
            gap = 0;
            burst = $urandom_range(10, 40);
         end else begin
            gap = $urandom_range(0, 7);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.kind         = rsp_kind;
         got.command      = rsp_command;
         got.data         = rsp_data;
         got.byte_index   = rsp_byte_index;
         got.frame_length = rsp_frame_length;
         got.status       = rsp_status;
         board.match_response(got);
      end
   end

   initial begin : stimulus
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings. A byte other than the start byte is
      // ignored while hunting. The first frame is empty, so the CRC follows the command
      // at once, and it closes on the start byte instead of the end byte: the end result
      // must report the missing end byte and that byte must not open a new frame.
      send_byte(8'h00);
      drive_frame(8'hFF, 16'd0, 16'h0000, START_BYTE_RESET);
      wait_until_drained();

      // With a limit of one, a two-byte payload emits its first byte only and the frame
      // closes as over the limit; then an empty frame with a spoiled CRC.
      write_settings(START_BYTE_RESET, END_BYTE_RESET, 16'd1, 1'b0);
      drive_frame(8'h00, 16'd2, 16'h0000, END_BYTE_RESET);
      drive_frame(8'h5A, 16'd0, 16'h8001, END_BYTE_RESET);
      wait_until_drained();

      // Reset settings again, plus a write to the unused index that must change nothing.
      // One long frame just over the limit comes first, and the response side stalls
      // during it so that the block backs up and holds off requests.
      write_settings(START_BYTE_RESET, END_BYTE_RESET, MAX_PAYLOAD_RESET, 1'b1);
      stall_request = 1'b1;
      random_traffic(PHASE_ITEMS, MAX_PAYLOAD_RESET + 16'($urandom_range(1, 40)));
      wait_until_drained();

      // Extremes: a zero limit, so every non-empty frame is over the limit ...
      write_settings(8'h00, 8'hFF, 16'h0000, 1'b0);
      random_traffic(PHASE_ITEMS, 16'd0);
      wait_until_drained();

      // ... and the largest limit with the delimiters the other way round.
      write_settings(8'hFF, 8'h00, 16'hFFFF, 1'b0);
      random_traffic(PHASE_ITEMS, 16'd0);
      wait_until_drained();

      // Random delimiters with a small limit that the longer frames cross.
      write_settings(8'($urandom), 8'($urandom), 16'($urandom_range(1, 16)), 1'b1);
      random_traffic(PHASE_ITEMS, 16'd0);
      wait_until_drained();

      write_settings(8'($urandom), 8'($urandom), 16'($urandom_range(13, 600)), 1'b0);
      random_traffic(PHASE_ITEMS, 16'd0);
      wait_until_drained();

      $display("Sent %0d requests under seven settings; checked %0d payload bytes.",
               requests_sent, board.payload_seen);
      $display("Frame closes by status: ok %0d, CRC bad %0d, end missing %0d, over limit %0d.",
               board.closes_seen[STATUS_OK], board.closes_seen[STATUS_CRC_BAD],
               board.closes_seen[STATUS_NO_END], board.closes_seen[STATUS_OVER_MAX]);
      if (board.mismatches == 0) begin
         $display("crc16_frame_receiver_test passed");
      end else begin
         $display("%0d mismatches found.", board.mismatches);
         $display("crc16_frame_receiver_test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Timeout after %0d ns with %0d responses outstanding.",
               TIMEOUT_NS, board.awaited.size());
      $display("crc16_frame_receiver_test failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/frx_pkg.sv
sv/frx_csr.sv
sv/frx_in_reg.sv
sv/frx_parser.sv
sv/frx_out_reg.sv
sv/crc16_frame_receiver.sv
tb/crc16_frame_receiver_test.sv
